FILE: hw/rtl/timer_expiry_queue_macros.svh
// assertion macros used by the timer queue core
`ifndef TIMER_EXPIRY_QUEUE_MACROS_SVH
`define TIMER_EXPIRY_QUEUE_MACROS_SVH

// condition holds on every clock edge out of reset
`define TEQ_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define TEQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define TEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/timeq_pkg.sv
// shared constants and command codes of the timer expiry queue
package timeq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_TIME_BITS   = 32;
    localparam int DEF_HANDLE_BITS = 16;
    localparam int COUNT_W         = 5;

    typedef enum logic {
        CMD_INSERT  = 1'b0,
        CMD_SERVICE = 1'b1
    } cmd_t;

endpackage

FILE: hw/rtl/timeq_front.sv
// front end: accepts commands, forms the expiry key and queues them for the core
module timeq_front #(
    parameter int TIME_BITS   = 32,
    parameter int HANDLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  timeq_pkg::cmd_t        cmd,
    input  logic [HANDLE_BITS-1:0] timer_handle,
    input  logic [TIME_BITS-1:0]   start_time,
    input  logic [TIME_BITS-1:0]   timeout,
    input  logic [TIME_BITS-1:0]   now_time,
    output logic                   q_valid,
    output timeq_pkg::cmd_t        q_cmd,
    output logic [HANDLE_BITS-1:0] q_handle,
    output logic [TIME_BITS:0]     q_key,
    input  logic                   q_pop
);
    import timeq_pkg::*;

    localparam int KEY_W = TIME_BITS + 1;

    cmd_t                   cmd_mem_reg    [2];
    logic [HANDLE_BITS-1:0] handle_mem_reg [2];
    logic [KEY_W-1:0]       key_mem_reg    [2];
    logic                   wr_ptr_reg, wr_ptr_next;
    logic                   rd_ptr_reg, rd_ptr_next;
    logic [1:0]             cnt_reg, cnt_next;
    logic [KEY_W-1:0]       in_key;
    logic                   accept;
    logic                   take;

    // service carries the current tick, insert carries start plus timeout
    always_comb
    begin
        if (cmd == CMD_SERVICE)
        begin
            in_key = KEY_W'(now_time);
        end
        else
        begin
            in_key = KEY_W'(start_time) + KEY_W'(timeout);
        end
    end

    assign full     = (cnt_reg == 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign accept   = push && !full;
    assign take     = q_pop && q_valid;
    assign q_cmd    = cmd_mem_reg[rd_ptr_reg];
    assign q_handle = handle_mem_reg[rd_ptr_reg];
    assign q_key    = key_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = accept ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? !rd_ptr_reg : rd_ptr_reg;
        case ({accept, take})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_mem_reg[wr_ptr_reg]    <= cmd;
            handle_mem_reg[wr_ptr_reg] <= timer_handle;
            key_mem_reg[wr_ptr_reg]    <= in_key;
        end
    end

endmodule

FILE: hw/rtl/timeq_core.sv
// back end: sorted row of timer cells, one insert or one expiry per cycle while the result queue has room
`include "timer_expiry_queue_macros.svh"

module timeq_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 32,
    parameter int HANDLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  timeq_pkg::cmd_t               q_cmd,
    input  logic [HANDLE_BITS-1:0]        q_handle,
    input  logic [TIME_BITS:0]            q_key,
    output logic                          q_pop,
    input  logic                          res_full,
    output logic                          res_push,
    output logic                          res_expired_valid,
    output logic [HANDLE_BITS-1:0]        res_handle,
    output logic                          res_last,
    output logic                          res_dropped,
    output logic [timeq_pkg::COUNT_W-1:0] res_count,
    output logic                          res_empty,
    output logic [TIME_BITS:0]            res_next
);
    import timeq_pkg::*;

    localparam int KEY_W = TIME_BITS + 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [KEY_W-1:0]       exp_reg [QUEUE_DEPTH];
    logic [HANDLE_BITS-1:0] hdl_reg [QUEUE_DEPTH];
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [QUEUE_DEPTH-1:0] ins;
    logic                   go;
    logic                   is_ins;
    logic                   full_q;
    logic                   due;
    logic                   do_ins;
    logic                   do_pop;
    logic [KEY_W-1:0]       post_head;

    assign go     = q_valid && !res_full;
    assign is_ins = (q_cmd == CMD_INSERT);
    assign full_q = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign due    = (count_reg != '0) && (exp_reg[0] <= q_key);
    assign do_ins = go && is_ins && !full_q;
    assign do_pop = go && !is_ins && due;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            // later cells move up; the key goes to the first later cell, or to the first free cell
            assign ins[g] = (CNT_W'(g) < count_reg) ? (exp_reg[g] > q_key)
                                                    : (count_reg == CNT_W'(g));

            always_ff @(posedge clk)
            begin
                if (do_ins && ins[g])
                begin
                    if (g == 0)
                    begin
                        exp_reg[g] <= q_key;
                        hdl_reg[g] <= q_handle;
                    end
                    else if (!ins[(g == 0) ? 0 : g-1])
                    begin
                        exp_reg[g] <= q_key;
                        hdl_reg[g] <= q_handle;
                    end
                    else
                    begin
                        exp_reg[g] <= exp_reg[(g == 0) ? 0 : g-1];
                        hdl_reg[g] <= hdl_reg[(g == 0) ? 0 : g-1];
                    end
                end
                else if (do_pop && (g < QUEUE_DEPTH - 1))
                begin
                    exp_reg[g] <= exp_reg[(g < QUEUE_DEPTH - 1) ? g+1 : g];
                    hdl_reg[g] <= hdl_reg[(g < QUEUE_DEPTH - 1) ? g+1 : g];
                end
            end
        end
    endgenerate

    always_comb
    begin
        if (do_ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // status seen after this beat
    always_comb
    begin
        if (do_ins)
        begin
            post_head = ((count_reg == '0) || (exp_reg[0] > q_key)) ? q_key : exp_reg[0];
        end
        else if (do_pop)
        begin
            post_head = exp_reg[1];
        end
        else
        begin
            post_head = exp_reg[0];
        end
    end

    assign res_push          = go;
    assign res_expired_valid = do_pop;
    assign res_handle        = do_pop ? hdl_reg[0] : '0;
    assign res_last          = !do_pop || (count_reg == CNT_W'(1)) || (exp_reg[1] > q_key);
    assign res_dropped       = is_ins && full_q;
    assign res_count         = COUNT_W'(count_next);
    assign res_empty         = (count_next == '0);
    assign res_next          = res_empty ? '1 : post_head;
    // a service command stays at the head until its final expiry beat
    assign q_pop             = go && res_last;

    `TEQ_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(QUEUE_DEPTH), "count above depth")
    `TEQ_ASSERT_IMPLY(a_head_sorted, count_reg >= CNT_W'(2), exp_reg[0] <= exp_reg[1], "head out of order")
    `TEQ_ASSERT_NEXT(a_pop_count, do_pop, count_reg == $past(count_reg) - CNT_W'(1), "pop miscounted")
    `TEQ_ASSERT_IMPLY(a_drop_only_full, res_push && res_dropped, count_reg == CNT_W'(QUEUE_DEPTH), "drop with room")

endmodule

FILE: hw/rtl/timeq_rsq.sv
// two-entry result queue that decouples the core from the result consumer
module timeq_rsq #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    output logic             empty,
    output logic [WIDTH-1:0] dout,
    input  logic             pop
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             wr;
    logic             rd;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign wr    = push && !full;
    assign rd    = pop && !empty;
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd ? !rd_ptr_reg : rd_ptr_reg;
        case ({wr, rd})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

FILE: hw/rtl/timer_expiry_queue.sv
// Sorted timer queue. Commands enter through a two-entry front queue where the insert
// expiry (start_time + timeout, one bit wider so it never wraps) is formed; the core
// keeps pending timers in a row of QUEUE_DEPTH cells sorted by expiry, equal expiries
// in arrival order. An insert is done at once (all cells compare against the new
// expiry in parallel and shift in one step); a service gives one result beat per expired
// timer, or one beat when nothing is due. Results pass through a two-entry result
// queue, so a command's first beat is registered in the front queue and again in the
// result queue before it is visible, and the core only stalls when that queue is full.
// An insert into a full queue is refused with dropped set.
module timer_expiry_queue #(
    parameter int QUEUE_DEPTH = timeq_pkg::DEF_QUEUE_DEPTH,
    parameter int TIME_BITS   = timeq_pkg::DEF_TIME_BITS,
    parameter int HANDLE_BITS = timeq_pkg::DEF_HANDLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  timeq_pkg::cmd_t               cmd,
    input  logic [HANDLE_BITS-1:0]        timer_handle,
    input  logic [TIME_BITS-1:0]          start_time,
    input  logic [TIME_BITS-1:0]          timeout,
    input  logic [TIME_BITS-1:0]          now_time,
    output logic                          empty,
    input  logic                          pop,
    output logic                          expired_valid,
    output logic [HANDLE_BITS-1:0]        expired_handle,
    output logic                          last,
    output logic                          dropped,
    output logic [timeq_pkg::COUNT_W-1:0] pending_count,
    output logic                          queue_empty,
    output logic [TIME_BITS:0]            next_expiry
);
    import timeq_pkg::*;

    localparam int RES_W = HANDLE_BITS + COUNT_W + TIME_BITS + 5;

    logic                   q_valid;
    cmd_t                   q_cmd;
    logic [HANDLE_BITS-1:0] q_handle;
    logic [TIME_BITS:0]     q_key;
    logic                   q_pop;
    logic                   res_full;
    logic                   res_push;
    logic                   res_expired_valid;
    logic [HANDLE_BITS-1:0] res_handle;
    logic                   res_last;
    logic                   res_dropped;
    logic [COUNT_W-1:0]     res_count;
    logic                   res_empty;
    logic [TIME_BITS:0]     res_next;
    logic [RES_W-1:0]       res_din;
    logic [RES_W-1:0]       res_dout;

    timeq_front #(
        .TIME_BITS   (TIME_BITS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .cmd          (cmd),
        .timer_handle (timer_handle),
        .start_time   (start_time),
        .timeout      (timeout),
        .now_time     (now_time),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_handle     (q_handle),
        .q_key        (q_key),
        .q_pop        (q_pop)
    );

    timeq_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_BITS   (TIME_BITS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (q_valid),
        .q_cmd             (q_cmd),
        .q_handle          (q_handle),
        .q_key             (q_key),
        .q_pop             (q_pop),
        .res_full          (res_full),
        .res_push          (res_push),
        .res_expired_valid (res_expired_valid),
        .res_handle        (res_handle),
        .res_last          (res_last),
        .res_dropped       (res_dropped),
        .res_count         (res_count),
        .res_empty         (res_empty),
        .res_next          (res_next)
    );

    assign res_din = {res_expired_valid, res_handle, res_last, res_dropped,
                      res_count, res_empty, res_next};

    timeq_rsq #(
        .WIDTH (RES_W)
    ) u_rsq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_din),
        .full  (res_full),
        .empty (empty),
        .dout  (res_dout),
        .pop   (pop)
    );

    assign {expired_valid, expired_handle, last, dropped,
            pending_count, queue_empty, next_expiry} = res_dout;

endmodule

FILE: bench/timer_expiry_queue_tb.sv
// self-checking testbench for the sorted timer expiry queue
module timer_expiry_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import timeq_pkg::*;

    localparam int DEPTH = DEF_QUEUE_DEPTH;
    localparam int TBITS = DEF_TIME_BITS;
    localparam int HBITS = DEF_HANDLE_BITS;
    localparam int CBITS = COUNT_W;
    localparam int RANDOM_CMDS = 350;
    localparam int HOLD_AFTER_BEATS = 60;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;

    class timer_queue_tracker;
        typedef struct packed {
            logic [TBITS:0]   expiry;
            logic [HBITS-1:0] handle;
        } timer_t;

        typedef struct packed {
            logic             fired;
            logic [HBITS-1:0] handle;
            logic             last;
            logic             dropped;
            logic [CBITS-1:0] count;
            logic             idle;
            logic [TBITS:0]   next_exp;
        } beat_t;

        timer_t armed_timers[$];
        beat_t  due_beats[$];
        int     mismatches;

        function new();
            mismatches = 0;
        endfunction

        // status fields reflect the queue after the beat's own removal
        function void add_beat(logic fired, logic [HBITS-1:0] h, logic last, logic dropped);
            beat_t b;
            b.fired    = fired;
            b.handle   = h;
            b.last     = last;
            b.dropped  = dropped;
            b.count    = CBITS'(armed_timers.size());
            b.idle     = (armed_timers.size() == 0);
            b.next_exp = b.idle ? '1 : armed_timers[0].expiry;
            due_beats.push_back(b);
        endfunction

        function void record_command(cmd_t c, logic [HBITS-1:0] h, logic [TBITS-1:0] st,
                                     logic [TBITS-1:0] tmo, logic [TBITS-1:0] now);
            timer_t t;
            int pos;
            logic [TBITS:0] now_w;
            if (c == CMD_INSERT) begin
                if (armed_timers.size() >= DEPTH) begin
                    add_beat(1'b0, '0, 1'b1, 1'b1);
                    return;
                end
                t.expiry = {1'b0, st} + {1'b0, tmo};
                t.handle = h;
                pos = 0;
                while (pos < armed_timers.size() && armed_timers[pos].expiry <= t.expiry)
                    pos++;
                armed_timers.insert(pos, t);
                add_beat(1'b0, '0, 1'b1, 1'b0);
            end
            else begin
                now_w = {1'b0, now};
                if (armed_timers.size() == 0 || armed_timers[0].expiry > now_w) begin
                    add_beat(1'b0, '0, 1'b1, 1'b0);
                    return;
                end
                while (armed_timers.size() > 0 && armed_timers[0].expiry <= now_w) begin
                    t = armed_timers.pop_front();
                    add_beat(1'b1, t.handle,
                             armed_timers.size() == 0 || armed_timers[0].expiry > now_w,
                             1'b0);
                end
            end
        endfunction

        function void compare_beat(beat_t got);
            beat_t want;
            if (due_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with nothing expected: %p", $realtime, got);
                return;
            end
            want = due_beats.pop_front();
            if (got.fired !== want.fired || got.handle !== want.handle
                || got.last !== want.last || got.dropped !== want.dropped
                || got.count !== want.count || got.idle !== want.idle
                || got.next_exp !== want.next_exp) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
            end
        endfunction

        function int outstanding();
            return due_beats.size();
        endfunction

        function int failures();
            return mismatches + due_beats.size();
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    cmd_t             cmd = CMD_INSERT;
    logic [HBITS-1:0] timer_handle = '0;
    logic [TBITS-1:0] start_time = '0;
    logic [TBITS-1:0] timeout = '0;
    logic [TBITS-1:0] now_time = '0;
    logic             empty;
    logic             pop = 1'b0;
    logic             expired_valid;
    logic [HBITS-1:0] expired_handle;
    logic             last;
    logic             dropped;
    logic [CBITS-1:0] pending_count;
    logic             queue_empty;
    logic [TBITS:0]   next_expiry;

    timer_queue_tracker tracker = new();
    int burst_left = 0;
    int beats_seen = 0;

    timer_expiry_queue i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .cmd            (cmd),
        .timer_handle   (timer_handle),
        .start_time     (start_time),
        .timeout        (timeout),
        .now_time       (now_time),
        .empty          (empty),
        .pop            (pop),
        .expired_valid  (expired_valid),
        .expired_handle (expired_handle),
        .last           (last),
        .dropped        (dropped),
        .pending_count  (pending_count),
        .queue_empty    (queue_empty),
        .next_expiry    (next_expiry)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // offers one command and returns once the block has taken it
    task automatic send_cmd(cmd_t c, logic [HBITS-1:0] h, logic [TBITS-1:0] st,
                            logic [TBITS-1:0] tmo, logic [TBITS-1:0] now);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        push         <= 1'b1;
        cmd          <= c;
        timer_handle <= h;
        start_time   <= st;
        timeout      <= tmo;
        now_time     <= now;
        do @(posedge clk); while (full !== 1'b0);
        tracker.record_command(c, h, st, tmo, now);
    endtask

    task automatic insert_timer(logic [HBITS-1:0] h, logic [TBITS-1:0] st,
                                logic [TBITS-1:0] tmo);
        send_cmd(CMD_INSERT, h, st, tmo, $urandom);
    endtask

    task automatic service_at(logic [TBITS-1:0] now);
        send_cmd(CMD_SERVICE, $urandom_range(0, 65535), $urandom, $urandom, now);
    endtask

    // result side: checks every beat taken, stalls on a mode pattern with one long hold-off
    initial
    begin : result_sink
        int  mode;
        int  mode_left;
        int  hold_left;
        bit  held;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        held = 1'b0;
        forever begin
            @(posedge clk);
            if (pop && !empty) begin
                tracker.compare_beat({expired_valid, expired_handle, last, dropped,
                                      pending_count, queue_empty, next_expiry});
                beats_seen++;
            end
            if (!held && beats_seen >= HOLD_AFTER_BEATS) begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end
            else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 100);
                end
                mode_left--;
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= $urandom_range(0, 1);
                    default: pop <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        logic [TBITS-1:0] tick;
        logic [TBITS-1:0] st;
        logic [TBITS-1:0] tmo;
        int seg_left;
        int insert_pct;
        int off;
        seg_left = 0;
        insert_pct = 50;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty service, equal expiries, a full drain, refusal when full
        service_at('0);
        insert_timer('0, '0, '0);
        insert_timer('1, 32'd5, '0);
        insert_timer(16'd1, '0, 32'd5);
        service_at(32'd4);
        service_at(32'd5);
        for (int i = 0; i < DEPTH; i++) begin
            if (i % 4 == 0)
                insert_timer($urandom_range(0, 65535), 32'd100, 32'd100);
            else
                insert_timer($urandom_range(0, 65535), $urandom_range(0, 1000),
                             $urandom_range(0, 1000));
        end
        insert_timer(16'h5a5a, '0, '0);
        service_at('1);
        // widest expiry never comes due; it stays parked at the tail
        insert_timer(16'ha5a5, '1, '1);
        service_at('1);

        tick = $urandom_range(0, 32'hfff0_0000);
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(10, 50);
                insert_pct = $urandom_range(30, 90);
            end
            seg_left--;
            if ($urandom_range(0, 99) < insert_pct) begin
                if ($urandom_range(0, 39) == 0) begin
                    st = $urandom;
                    tmo = $urandom;
                end
                else begin
                    off = $urandom_range(0, 63);
                    st = (tick >= off) ? tick - off : tick;
                    tmo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5000)
                                                      : $urandom_range(0, 300);
                end
                insert_timer($urandom_range(0, 65535), st, tmo);
            end
            else if ($urandom_range(0, 9) == 0) begin
                service_at($urandom);
            end
            else begin
                tick = tick + $urandom_range(0, 120);
                service_at(tick);
            end
        end
        push <= 1'b0;

        while (tracker.outstanding() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.failures() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: timer_expiry_queue.f
+incdir+hw/rtl
hw/rtl/timeq_pkg.sv
hw/rtl/timeq_front.sv
hw/rtl/timeq_core.sv
hw/rtl/timeq_rsq.sv
hw/rtl/timer_expiry_queue.sv
bench/timer_expiry_queue_tb.sv
